// ----- hw/rtl/prh_pkg.sv -----
// Types and constants shared by the pixel residual histogram block.
package prh_pkg;

   localparam int unsigned VALUE_BINS      = 256;
   localparam int unsigned RESIDUAL_BINS   = 512;
   localparam int unsigned RESIDUAL_OFFSET = 255;
   localparam int unsigned ROW_PRED_RESET  = 128;

   localparam int unsigned VALUE_AW    = 8;
   localparam int unsigned RESIDUAL_AW = 9;
   localparam int unsigned IWIDTH_W    = 14;
   localparam int unsigned PIXEL_W     = 8;
   localparam int unsigned CSR_AW      = 3;
   localparam int unsigned CSR_DW      = 32;
   localparam int unsigned OUT_COUNT_W = 32;

   typedef enum logic [1:0] {
      MODE_PIXEL         = 2'd0,
      MODE_READ_VALUE    = 2'd1,
      MODE_READ_RESIDUAL = 2'd2,
      MODE_CLEAR         = 2'd3
   } prh_mode_type;

   typedef enum logic {
      REG_IMAGE_WIDTH = 1'b0,
      REG_ROW_PRED    = 1'b1
   } prh_reg_type;

   typedef struct packed {
      prh_mode_type             mode;
      logic [PIXEL_W-1:0]       pixel;
      logic [RESIDUAL_AW-1:0]   bin;
   } prh_req_type;

   typedef struct packed {
      logic signed [RESIDUAL_AW-1:0] residual;
      logic [OUT_COUNT_W-1:0]        count;
   } prh_rsp_type;

endpackage

// ----- hw/rtl/pixel_residual_histogram.sv -----
// Left-prediction residual histogram: value and residual bin counters in two RAMs.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_stall | prh_req_type {mode, pixel, bin}
//   rsp_    | out       | rsp_valid / rsp_stall | prh_rsp_type {residual, count}
//   csr_    | in / out  | APB, pready tied high | image_width @0x0, row_start_prediction @0x4
//
// One request per cycle while req_stall is low; each result is registered in the
// read stage and then in the output register. Each RAM is read at acceptance and
// written back as the request leaves the read stage; the last write is forwarded
// to a following read of the same bin. After reset a clearing pass zeroes both
// RAMs with req_stall high. A stalled result holds in the output register; one more
// request completes into the read stage, then req_stall rises until rsp_stall falls.
module pixel_residual_histogram #(
   parameter int COUNT_WIDTH = 32,
   parameter int MAX_WIDTH   = 8192
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  prh_pkg::prh_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output prh_pkg::prh_rsp_type            rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [prh_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [prh_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [prh_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                            csr_pready
);
   import prh_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EW_W  = ($clog2(MAX_WIDTH + 1) > IWIDTH_W) ? $clog2(MAX_WIDTH + 1) : IWIDTH_W;

   // configuration
   logic [IWIDTH_W-1:0] image_width_ff;
   logic [PIXEL_W-1:0]  row_pred_ff;
   logic                csr_we;
   prh_reg_type         csr_reg;

   // row tracking
   logic [PIXEL_W-1:0]  prev_pixel_ff;
   logic [COL_W-1:0]    col_ff;
   logic [COL_W-1:0]    col_in;
   logic [EW_W-1:0]     iw_ext;
   logic [EW_W-1:0]     eff_width;
   logic [EW_W-1:0]     col_inc;

   // clearing pass
   logic                   clr_active_ff;
   logic [RESIDUAL_AW-1:0] clr_idx_ff;

   // memories
   logic [COUNT_WIDTH-1:0] vmem [VALUE_BINS];
   logic [COUNT_WIDTH-1:0] rmem [RESIDUAL_BINS];
   logic [COUNT_WIDTH-1:0] vmem_rd_ff;
   logic [COUNT_WIDTH-1:0] rmem_rd_ff;

   // accept stage
   logic                   req_accept;
   logic [PIXEL_W-1:0]     pred;
   logic [RESIDUAL_AW-1:0] diff;
   logic [RESIDUAL_AW-1:0] ridx;
   logic [VALUE_AW-1:0]    vaddr_in;
   logic [RESIDUAL_AW-1:0] raddr_in;

   // read stage
   logic                   s1_valid_ff;
   prh_mode_type           s1_mode_ff;
   logic [VALUE_AW-1:0]    s1_vaddr_ff;
   logic [RESIDUAL_AW-1:0] s1_raddr_ff;
   logic                   s1_vok_ff;
   logic [RESIDUAL_AW-1:0] s1_residual_ff;
   logic [COUNT_WIDTH-1:0] v_cur;
   logic [COUNT_WIDTH-1:0] r_cur;
   logic [COUNT_WIDTH-1:0] v_new;
   logic [COUNT_WIDTH-1:0] r_new;
   logic                   out_free;
   logic                   s1_advance;
   prh_rsp_type            s1_rsp;

   // write ports and forwarding
   logic                   vwr_en;
   logic [VALUE_AW-1:0]    vwr_addr;
   logic [COUNT_WIDTH-1:0] vwr_data;
   logic                   rwr_en;
   logic [RESIDUAL_AW-1:0] rwr_addr;
   logic [COUNT_WIDTH-1:0] rwr_data;
   logic                   vbyp_valid_ff;
   logic [VALUE_AW-1:0]    vbyp_addr_ff;
   logic [COUNT_WIDTH-1:0] vbyp_data_ff;
   logic                   rbyp_valid_ff;
   logic [RESIDUAL_AW-1:0] rbyp_addr_ff;
   logic [COUNT_WIDTH-1:0] rbyp_data_ff;

   // output register
   logic        rsp_valid_ff;
   prh_rsp_type rsp_data_ff;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = prh_reg_type'(csr_paddr[2]);

   always_comb begin
      case (csr_reg)
         REG_IMAGE_WIDTH: csr_prdata = CSR_DW'(image_width_ff);
         REG_ROW_PRED:    csr_prdata = CSR_DW'(row_pred_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= IWIDTH_W'(1);
         row_pred_ff    <= PIXEL_W'(ROW_PRED_RESET);
      end else if (csr_we) begin
         case (csr_reg)
            REG_IMAGE_WIDTH: image_width_ff <= csr_pwdata[IWIDTH_W-1:0];
            REG_ROW_PRED:    row_pred_ff    <= csr_pwdata[PIXEL_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- accept stage ----------------
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_stall  = clr_active_ff || (s1_valid_ff && !out_free);
   assign req_accept = req_valid && !req_stall;

   assign pred = (col_ff == '0) ? row_pred_ff : prev_pixel_ff;
   assign diff = {1'b0, req_data.pixel} - {1'b0, pred};
   assign ridx = diff + RESIDUAL_AW'(RESIDUAL_OFFSET);

   assign iw_ext  = EW_W'(image_width_ff);
   assign col_inc = EW_W'(col_ff) + EW_W'(1);

   always_comb begin
      if (iw_ext == '0) begin
         eff_width = EW_W'(1);
      end else if (iw_ext > EW_W'(MAX_WIDTH)) begin
         eff_width = EW_W'(MAX_WIDTH);
      end else begin
         eff_width = iw_ext;
      end
      col_in = (col_inc >= eff_width) ? '0 : col_inc[COL_W-1:0];
   end

   always_comb begin
      if (req_data.mode == MODE_PIXEL) begin
         vaddr_in = req_data.pixel;
         raddr_in = ridx;
      end else begin
         vaddr_in = req_data.bin[VALUE_AW-1:0];
         raddr_in = req_data.bin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pixel_ff <= '0;
         col_ff        <= '0;
      end else if (req_accept) begin
         case (req_data.mode)
            MODE_PIXEL: begin
               prev_pixel_ff <= req_data.pixel;
               col_ff        <= col_in;
            end
            MODE_CLEAR: col_ff <= '0;
            default: ;
         endcase
      end
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (vwr_en) begin
         vmem[vwr_addr] <= vwr_data;
      end
      if (req_accept) begin
         vmem_rd_ff <= vmem[vaddr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (rwr_en) begin
         rmem[rwr_addr] <= rwr_data;
      end
      if (req_accept) begin
         rmem_rd_ff <= rmem[raddr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
      end else if (clr_active_ff) begin
         clr_idx_ff <= clr_idx_ff + RESIDUAL_AW'(1);
         if (clr_idx_ff == '1) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   // ---------------- read stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff     <= req_data.mode;
         s1_vaddr_ff    <= vaddr_in;
         s1_raddr_ff    <= raddr_in;
         s1_vok_ff      <= (req_data.mode == MODE_PIXEL) || !req_data.bin[RESIDUAL_AW-1];
         s1_residual_ff <= diff;
      end
   end

   assign v_cur = (vbyp_valid_ff && vbyp_addr_ff == s1_vaddr_ff) ? vbyp_data_ff : vmem_rd_ff;
   assign r_cur = (rbyp_valid_ff && rbyp_addr_ff == s1_raddr_ff) ? rbyp_data_ff : rmem_rd_ff;
   assign v_new = (v_cur == '1) ? v_cur : v_cur + COUNT_WIDTH'(1);
   assign r_new = (r_cur == '1) ? r_cur : r_cur + COUNT_WIDTH'(1);

   always_comb begin
      s1_rsp = '0;
      vwr_en = 1'b0;
      rwr_en = 1'b0;
      vwr_addr = s1_vaddr_ff;
      rwr_addr = s1_raddr_ff;
      vwr_data = '0;
      rwr_data = '0;
      if (clr_active_ff) begin
         vwr_en   = 1'b1;
         rwr_en   = 1'b1;
         vwr_addr = clr_idx_ff[VALUE_AW-1:0];
         rwr_addr = clr_idx_ff;
      end
      case (s1_mode_ff)
         MODE_PIXEL: begin
            s1_rsp.residual = s1_residual_ff;
            if (s1_advance) begin
               vwr_en   = 1'b1;
               rwr_en   = 1'b1;
               vwr_data = v_new;
               rwr_data = r_new;
            end
         end
         MODE_READ_VALUE: begin
            if (s1_vok_ff) begin
               s1_rsp.count = OUT_COUNT_W'(v_cur);
            end
         end
         MODE_READ_RESIDUAL: s1_rsp.count = OUT_COUNT_W'(r_cur);
         MODE_CLEAR: begin
            if (s1_advance) begin
               vwr_en = s1_vok_ff;
               rwr_en = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vbyp_valid_ff <= 1'b0;
         rbyp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         if (vwr_en) begin
            vbyp_valid_ff <= 1'b1;
         end
         if (rwr_en) begin
            rbyp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && vwr_en) begin
         vbyp_addr_ff <= vwr_addr;
         vbyp_data_ff <= vwr_data;
      end
      if (s1_advance && rwr_en) begin
         rbyp_addr_ff <= rwr_addr;
         rbyp_data_ff <= rwr_data;
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff <= s1_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/prh_checker.sv -----
// Port-level assertions for the pixel residual histogram, bound to the top level.
module prh_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input prh_pkg::prh_rsp_type rsp_data
);
   import prh_pkg::*;

   // no result may come out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // clearing pass holds off requests after reset
   a_reset_clear: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during clearing pass");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a result carries a residual or a count, never both
   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.residual == '0 || rsp_data.count == '0)
      else $error("result has both residual and count");

endmodule

bind pixel_residual_histogram prh_checker u_prh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- dv/pixel_residual_histogram_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for pixel_residual_histogram: directed steps, then random raster traffic.
module pixel_residual_histogram_tb;
   import prh_pkg::*;

   localparam int BLOCK_MAX_WIDTH = 8192;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int PHASES          = 8;
   localparam int PHASE_ITEMS     = 112;
   localparam int MAX_REPORTS     = 200;

   typedef struct {
      logic              write_reg;
      prh_reg_type       reg_sel;
      logic [CSR_DW-1:0] reg_value;
      prh_req_type       request;
      logic              typed;
      prh_rsp_type       want;
   } step_row_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   prh_req_type       req_data    = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   prh_rsp_type       rsp_data;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   pixel_residual_histogram #(
      .COUNT_WIDTH(32),
      .MAX_WIDTH  (BLOCK_MAX_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [IWIDTH_W-1:0] cfg_width    = 14'd1;
   logic [PIXEL_W-1:0]  cfg_row_pred = 8'd128;
   logic [PIXEL_W-1:0]  last_pixel   = '0;
   int                  column       = 0;
   logic [31:0]         value_counts    [VALUE_BINS];
   logic [31:0]         residual_counts [RESIDUAL_BINS];
   prh_rsp_type         residual_count_queue [$];

   int   failures     = 0;
   int   cycles       = 0;
   int   hold_left    = 0;
   logic hold_request = 1'b0;
   logic steady       = 1'b0;
   step_row_type plan [$];

   function automatic prh_rsp_type apply_to_histograms(input prh_req_type r);
      prh_rsp_type            out;
      int                     pred;
      int                     diff;
      int                     span;
      logic [RESIDUAL_AW-1:0] ridx;
      out  = '0;
      span = (cfg_width == 0) ? 1 : (cfg_width > BLOCK_MAX_WIDTH) ? BLOCK_MAX_WIDTH : cfg_width;
      case (r.mode)
         MODE_PIXEL: begin
            pred = (column == 0) ? int'(cfg_row_pred) : int'(last_pixel);
            diff = int'(r.pixel) - pred;
            ridx = RESIDUAL_AW'(diff + RESIDUAL_OFFSET);
            if (value_counts[r.pixel] != '1) value_counts[r.pixel]++;
            if (residual_counts[ridx] != '1) residual_counts[ridx]++;
            last_pixel = r.pixel;
            column++;
            if (column >= span) column = 0;
            out.residual = diff[RESIDUAL_AW-1:0];
         end
         MODE_READ_VALUE: begin
            if (r.bin < VALUE_BINS) out.count = value_counts[r.bin[VALUE_AW-1:0]];
         end
         MODE_READ_RESIDUAL: begin
            out.count = residual_counts[r.bin];
         end
         default: begin
            if (r.bin < VALUE_BINS) value_counts[r.bin[VALUE_AW-1:0]] = '0;
            residual_counts[r.bin] = '0;
            column = 0;
         end
      endcase
      return out;
   endfunction

   function automatic step_row_type request_row(input prh_mode_type m, input int unsigned pix,
                                                input int unsigned idx, input logic typed = 1'b0,
                                                input int res = 0, input int unsigned cnt = 0);
      step_row_type s;
      s.write_reg     = 1'b0;
      s.reg_sel       = REG_IMAGE_WIDTH;
      s.reg_value     = '0;
      s.request.mode  = m;
      s.request.pixel = PIXEL_W'(pix);
      s.request.bin   = RESIDUAL_AW'(idx);
      s.typed         = typed;
      s.want.residual = res[RESIDUAL_AW-1:0];
      s.want.count    = cnt;
      return s;
   endfunction

   function automatic step_row_type register_row(input prh_reg_type sel,
                                                 input int unsigned value);
      step_row_type s;
      s           = request_row(MODE_PIXEL, 0, 0);
      s.write_reg = 1'b1;
      s.reg_sel   = sel;
      s.reg_value = value;
      return s;
   endfunction

   function automatic prh_req_type random_request();
      prh_req_type r;
      int          pick;
      r.mode  = MODE_PIXEL;
      r.pixel = PIXEL_W'($urandom);
      r.bin   = RESIDUAL_AW'($urandom);
      pick    = $urandom_range(0, 99);
      if (pick < 70) begin
         if (pick < 35)
            r.pixel = PIXEL_W'(int'(last_pixel) + int'($urandom_range(0, 6)) - 3);
      end else if (pick < 83) begin
         r.mode = MODE_READ_VALUE;
         if ($urandom_range(0, 1)) r.bin = RESIDUAL_AW'(last_pixel);
      end else if (pick < 96) begin
         r.mode = MODE_READ_RESIDUAL;
         if ($urandom_range(0, 1)) r.bin = RESIDUAL_AW'($urandom_range(245, 265));
      end else begin
         r.mode = MODE_CLEAR;
         if ($urandom_range(0, 1)) r.bin = RESIDUAL_AW'(last_pixel);
      end
      return r;
   endfunction

   task automatic send_request(input prh_req_type r, input logic typed, input prh_rsp_type given);
      prh_rsp_type predicted;
      while (!steady && $urandom_range(0, 99) < 35) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_to_histograms(r);
      residual_count_queue.push_back(typed ? given : predicted);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (residual_count_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ends at a falling edge with psel still high; the caller either chains or lowers it
   task automatic csr_transfer(input logic is_write, input prh_reg_type sel,
                               input logic [CSR_DW-1:0] wdata, output logic [CSR_DW-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
   endtask

   task automatic check_register(input prh_reg_type sel, input logic [CSR_DW-1:0] want);
      logic [CSR_DW-1:0] got;
      csr_transfer(1'b0, sel, '0, got);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== want) begin
         failures++;
         $error("%s: expected %0d, actual %0d", sel.name(), want, got);
      end
   endtask

   task automatic program_register(input prh_reg_type sel, input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] got;
      csr_transfer(1'b1, sel, value, got);
      if (sel == REG_IMAGE_WIDTH) cfg_width = value[IWIDTH_W-1:0];
      else cfg_row_pred = value[PIXEL_W-1:0];
      check_register(sel, value);
   endtask

   always @(posedge clock) begin
      prh_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (residual_count_queue.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $error("unexpected result: residual %0d, count %0d",
                      rsp_data.residual, rsp_data.count);
         end else begin
            want = residual_count_queue.pop_front();
            if (rsp_data.residual !== want.residual) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $error("residual: expected %0d, actual %0d", want.residual, rsp_data.residual);
            end
            if (rsp_data.count !== want.count) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $error("count: expected %0d, actual %0d", want.count, rsp_data.count);
            end
         end
      end
   end

   // result side: random stalls, one long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < 35);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      prh_rsp_type       none;
      logic [CSR_DW-1:0] width_value;
      int                n;
      none = '0;
      foreach (value_counts[i]) value_counts[i] = '0;
      foreach (residual_counts[i]) residual_counts[i] = '0;

      // reset defaults: width 1, so every pixel is predicted from the row start value
      plan.push_back(request_row(MODE_READ_VALUE,    0,   0, 1'b1, 0, 0));
      plan.push_back(request_row(MODE_READ_RESIDUAL, 0, 511, 1'b1, 0, 0));
      plan.push_back(request_row(MODE_READ_VALUE,    0, 511, 1'b1, 0, 0));
      plan.push_back(request_row(MODE_PIXEL,         0,   0, 1'b1, -128, 0));
      plan.push_back(request_row(MODE_PIXEL,       255,   0, 1'b1, 127, 0));
      plan.push_back(request_row(MODE_PIXEL,       128,   0, 1'b1, 0, 0));
      plan.push_back(request_row(MODE_READ_VALUE,    0, 255, 1'b1, 0, 1));
      plan.push_back(request_row(MODE_READ_RESIDUAL, 0, 127, 1'b1, 0, 1));
      plan.push_back(request_row(MODE_READ_RESIDUAL, 0, 382, 1'b1, 0, 1));
      plan.push_back(request_row(MODE_CLEAR,         0, 255, 1'b1, 0, 0));
      plan.push_back(request_row(MODE_READ_VALUE,    0, 255, 1'b1, 0, 0));
      plan.push_back(request_row(MODE_READ_RESIDUAL, 0, 255, 1'b1, 0, 0));
      plan.push_back(request_row(MODE_CLEAR,         0, 511, 1'b1, 0, 0));
      plan.push_back(request_row(MODE_READ_RESIDUAL, 0, 511, 1'b1, 0, 0));
      plan.push_back(request_row(MODE_CLEAR,         0, 300));
      // residual extremes; width 0 behaves as 1
      plan.push_back(register_row(REG_ROW_PRED, 0));
      plan.push_back(register_row(REG_IMAGE_WIDTH, 0));
      plan.push_back(request_row(MODE_PIXEL,       255,   0, 1'b1, 255, 0));
      plan.push_back(register_row(REG_ROW_PRED, 255));
      plan.push_back(request_row(MODE_PIXEL,         0,   0, 1'b1, -255, 0));
      plan.push_back(request_row(MODE_READ_RESIDUAL, 0, 510, 1'b1, 0, 1));
      plan.push_back(request_row(MODE_READ_RESIDUAL, 0,   0, 1'b1, 0, 1));
      // oversize width clamps; clear restarts the row but keeps the last pixel
      plan.push_back(register_row(REG_IMAGE_WIDTH, 16383));
      plan.push_back(request_row(MODE_PIXEL,        10,   0));
      plan.push_back(request_row(MODE_PIXEL,        20,   0));
      plan.push_back(request_row(MODE_CLEAR,         0,   0));
      plan.push_back(request_row(MODE_PIXEL,       255,   0));
      plan.push_back(request_row(MODE_READ_VALUE,    0,  20));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      check_register(REG_IMAGE_WIDTH, 1);
      check_register(REG_ROW_PRED, ROW_PRED_RESET);

      foreach (plan[i]) begin
         if (plan[i].write_reg) begin
            settle();
            program_register(plan[i].reg_sel, plan[i].reg_value);
         end else begin
            send_request(plan[i].request, plan[i].typed, plan[i].want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         case ($urandom_range(0, 9))
            0:       width_value = 0;
            1:       width_value = 1;
            2:       width_value = BLOCK_MAX_WIDTH;
            3:       width_value = 16383;
            4:       width_value = $urandom_range(BLOCK_MAX_WIDTH + 1, 16383);
            5:       width_value = $urandom_range(100, BLOCK_MAX_WIDTH - 1);
            default: width_value = $urandom_range(2, 12);
         endcase
         program_register(REG_IMAGE_WIDTH, width_value);
         case ($urandom_range(0, 3))
            0:       program_register(REG_ROW_PRED, 0);
            1:       program_register(REG_ROW_PRED, 255);
            default: program_register(REG_ROW_PRED, $urandom_range(0, 255));
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            n      = p * PHASE_ITEMS + k;
            steady = (n >= 200 && n < 350);
            if (n == 500) hold_request = 1'b1;
            send_request(random_request(), 1'b0, none);
         end
      end

      settle();
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/prh_pkg.sv
hw/rtl/pixel_residual_histogram.sv
hw/rtl/prh_checker.sv
dv/pixel_residual_histogram_tb.sv
